[rtl/dgsp_pkg.sv]
package dgsp_pkg;

   // field widths
   localparam int NODE_W     = 5;
   localparam int DIST_W     = 10;
   localparam int CNT_REG_W  = 6;

   // distance value meaning no edge / unreachable
   localparam logic [DIST_W-1:0] NO_EDGE = 10'd999;

   // reset value of the node count register
   localparam logic [CNT_REG_W-1:0] NODE_COUNT_RST = 6'd32;

   // request kinds carried on tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RUN  = 1'b1;

   // request tdata layout
   localparam int REQ_DATA_W = 32;
   localparam int ROW_LSB    = 0;
   localparam int COL_LSB    = 5;
   localparam int WEIGHT_LSB = 10;
   localparam int SOURCE_LSB = 20;

   // response tdata layout
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * NODE_W - DIST_W;

endpackage

[rtl/dense_graph_shortest_paths.sv]
// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    tdata: row, col, weight, source; tuser: req_type
// rsp       out  rsp_tvalid/tready    tdata: node, distance, predecessor; tlast: last
// csr       in   csr_we               csr_wdata: node_count
//
// A load item writes at most one cost memory entry. A run item of n nodes: accept, a
// seeding scan of the distances, up to n-2 rounds of a select scan and a relax scan (the
// relax scan reads the cost memory through its single read port), then an emit scan for
// the n-1 results, one per node other than the source.
// Synchronous active-high reset; the cost memory is not cleared, no clearing pass.
// req_tready is low for the whole of a run; a stalled result holds the emit scan.
module dense_graph_shortest_paths #(
   parameter int MAX_NODES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dgsp_pkg::REQ_DATA_W-1:0]     req_tdata,   // row, col, weight, source
   input  logic                                req_tuser,   // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dgsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // node, distance, predecessor
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [dgsp_pkg::CNT_REG_W-1:0]      csr_wdata    // node_count
);

   localparam int LIM       = (MAX_NODES < 32) ? MAX_NODES : 32;
   localparam int AW        = $clog2(LIM);
   localparam int CW        = $clog2(LIM + 1);
   localparam int NW        = $clog2(MAX_NODES);
   localparam int MEM_AW    = 2 * NW;
   localparam int MEM_DEPTH = 2 ** MEM_AW;
   localparam int DW        = dgsp_pkg::DIST_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_SELECT = 3'd2;
   localparam logic [2:0] S_RELAX  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   // request fields
   logic [dgsp_pkg::NODE_W-1:0] req_row, req_col, req_src;
   logic [DW-1:0]               req_weight, weight_sat;
   logic                        req_fire, load_ok, run_ok;
   logic [MEM_AW-1:0]           wr_addr, rd_addr;

   // control registers
   logic [2:0]                       state_ff, state_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic [AW-1:0]                    idx_d_ff, idx_d_in;
   logic                             pv_ff, pv_in;
   logic [AW-1:0]                    src_ff, src_in;
   logic [AW-1:0]                    next_ff, next_in;
   logic [DW-1:0]                    mind_ff, mind_in;
   logic                             found_ff, found_in;
   logic [CW-1:0]                    round_ff, round_in;
   logic [dgsp_pkg::CNT_REG_W-1:0]   node_count_ff, node_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dgsp_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;

   // storage
   logic [DW-1:0] cost_mem [MEM_DEPTH];
   logic [DW-1:0] mem_q_ff;
   logic [DW-1:0] dist_ff [LIM];
   logic [AW-1:0] prev_ff [LIM];
   logic          done_ff [LIM];

   // datapath
   logic [CW-1:0] n_eff;
   logic [AW-1:0] idx_a, rd_idx, row_sel;
   logic          in_range, last_c;
   logic [DW-1:0] dist_rd;
   logic [AW-1:0] prev_rd;
   logic          done_rd;
   logic [DW:0]   cand;
   logic          relax_upd, init_we, mark_done;

   // request decode
   assign req_row    = req_tdata[dgsp_pkg::ROW_LSB    +: dgsp_pkg::NODE_W];
   assign req_col    = req_tdata[dgsp_pkg::COL_LSB    +: dgsp_pkg::NODE_W];
   assign req_weight = req_tdata[dgsp_pkg::WEIGHT_LSB +: DW];
   assign req_src    = req_tdata[dgsp_pkg::SOURCE_LSB +: dgsp_pkg::NODE_W];
   assign weight_sat = (req_weight > dgsp_pkg::NO_EDGE) ? dgsp_pkg::NO_EDGE : req_weight;
   assign load_ok    = (int'(req_row) < MAX_NODES) && (int'(req_col) < MAX_NODES);
   assign run_ok     = (int'(req_src) < int'(n_eff));
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_addr    = {NW'(req_row), NW'(req_col)};

   // effective node count, clamped to the supported range
   always_comb begin
      if (node_count_ff < 6'd2) begin
         n_eff = CW'(2);
      end else if (int'(node_count_ff) > LIM) begin
         n_eff = CW'(LIM);
      end else begin
         n_eff = CW'(node_count_ff);
      end
   end

   // scan index and the single read port of the node arrays
   assign idx_a    = idx_ff[AW-1:0];
   assign in_range = (idx_ff < n_eff);
   assign rd_idx   = (state_ff == S_RELAX) ? idx_d_ff : idx_a;
   assign dist_rd  = dist_ff[rd_idx];
   assign prev_rd  = prev_ff[rd_idx];
   assign done_rd  = done_ff[rd_idx];

   // cost row read: source row while seeding, settled node's row while relaxing
   assign row_sel = (state_ff == S_INIT) ? src_ff : next_ff;
   assign rd_addr = {NW'(row_sel), NW'(idx_a)};

   // shared add and compare
   assign cand      = {1'b0, mind_ff} + {1'b0, mem_q_ff};
   assign relax_upd = pv_ff && (state_ff == S_RELAX) && !done_rd && (cand < {1'b0, dist_rd});
   assign init_we   = pv_ff && (state_ff == S_INIT);
   assign mark_done = (state_ff == S_SELECT) && !in_range && found_ff;

   // final result of a run: last node, or last but one when the source is last
   assign last_c = (int'(idx_ff) == int'(n_eff) - 1) ||
                   ((int'(idx_ff) == int'(n_eff) - 2) && (int'(src_ff) == int'(n_eff) - 1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      idx_d_in      = idx_a;
      pv_in         = 1'b0;
      src_in        = src_ff;
      next_in       = next_ff;
      mind_in       = mind_ff;
      found_in      = found_ff;
      round_in      = round_ff;
      node_count_in = node_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         node_count_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == dgsp_pkg::REQ_RUN) && run_ok) begin
               src_in   = AW'(req_src);
               idx_in   = '0;
               round_in = CW'(1);
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            if (in_range) begin
               pv_in  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               mind_in  = dgsp_pkg::NO_EDGE;
               found_in = 1'b0;
               next_in  = '0;
               state_in = (int'(n_eff) > 2) ? S_SELECT : S_EMIT;
            end
         end
         S_SELECT: begin
            if (in_range) begin
               if (!done_rd && (dist_rd < mind_ff)) begin
                  mind_in  = dist_rd;
                  next_in  = idx_a;
                  found_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = found_ff ? S_RELAX : S_EMIT;
            end
         end
         S_RELAX: begin
            if (in_range) begin
               pv_in  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               round_in = round_ff + 1'b1;
               mind_in  = dgsp_pkg::NO_EDGE;
               found_in = 1'b0;
               next_in  = '0;
               state_in = (int'(round_ff) + 2 < int'(n_eff)) ? S_SELECT : S_EMIT;
            end
         end
         S_EMIT: begin
            if (in_range) begin
               if (idx_a == src_ff) begin
                  idx_in = idx_ff + 1'b1;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {{dgsp_pkg::RSP_PAD_W{1'b0}}, dgsp_pkg::NODE_W'(prev_rd),
                                  dist_rd, dgsp_pkg::NODE_W'(idx_a)};
                  rsp_last_in  = last_c;
                  idx_in       = idx_ff + 1'b1;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         pv_ff         <= 1'b0;
         found_ff      <= 1'b0;
         round_ff      <= '0;
         node_count_ff <= dgsp_pkg::NODE_COUNT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pv_ff         <= pv_in;
         found_ff      <= found_in;
         round_ff      <= round_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_d_ff    <= idx_d_in;
      src_ff      <= src_in;
      next_ff     <= next_in;
      mind_ff     <= mind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // cost memory: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == dgsp_pkg::REQ_LOAD) && load_ok) begin
         cost_mem[wr_addr] <= weight_sat;
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= cost_mem[rd_addr];
   end

   // node arrays: seeding, relaxation and settling
   always_ff @(posedge clock) begin
      if (init_we) begin
         dist_ff[idx_d_ff] <= (idx_d_ff == src_ff) ? '0 : mem_q_ff;
         prev_ff[idx_d_ff] <= src_ff;
         done_ff[idx_d_ff] <= (idx_d_ff == src_ff);
      end
      if (relax_upd) begin
         dist_ff[idx_d_ff] <= cand[DW-1:0];
         prev_ff[idx_d_ff] <= next_ff;
      end
      if (mark_done) begin
         done_ff[next_ff] <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a relaxed distance stays within the no-edge bound
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      relax_upd |-> (cand < {1'b0, dgsp_pkg::NO_EDGE}))
      else $error("relaxed distance reaches the no-edge value");

   // a settled node was reachable
   a_pick_reachable: assert property (@(posedge clock) disable iff (reset)
      mark_done |-> (mind_ff < dgsp_pkg::NO_EDGE))
      else $error("settled node with no finite distance");

   // the read pipeline is empty whenever requests are taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pv_ff)
      else $error("cost read still in flight while idle");
`endif

endmodule

[test/dgsp_path_checker.sv]
`timescale 1ns / 100ps

module dgsp_path_checker #(
   parameter int MAX_NODES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dgsp_pkg::REQ_DATA_W-1:0]     req_tdata,   // row, col, weight, source
   input  logic                                req_tuser,   // req_type
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dgsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // node, distance, predecessor
   input  logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [dgsp_pkg::CNT_REG_W-1:0]      csr_wdata,   // node_count
   output int                                  pending,
   output int                                  fail_count
);

   typedef struct packed {
      logic [dgsp_pkg::NODE_W-1:0] node;
      logic [dgsp_pkg::DIST_W-1:0] distance;
      logic [dgsp_pkg::NODE_W-1:0] predecessor;
      logic                        last;
   } path_result_type;

   // predictor state: cost matrix, node count register, results still to come
   logic [dgsp_pkg::DIST_W-1:0]    arc_cost [32][32];
   logic [dgsp_pkg::CNT_REG_W-1:0] node_limit;
   path_result_type                expected_paths [$];

   // register value clamped to the usable node range
   function automatic int active_count(input logic [dgsp_pkg::CNT_REG_W-1:0] value);
      int n;
      n = int'(value);
      if (n < 2) n = 2;
      if (n > MAX_NODES) n = MAX_NODES;
      if (n > 32) n = 32;
      return n;
   endfunction

   // Dijkstra from src over the active nodes; queue one item per other node
   task automatic solve_from(input logic [dgsp_pkg::NODE_W-1:0] src);
      int                          n, i, round, pick, final_node;
      int unsigned                 nearest, cand;
      logic [dgsp_pkg::DIST_W-1:0] reach [32];
      logic [dgsp_pkg::NODE_W-1:0] via [32];
      logic                        settled [32];
      logic                        found;
      path_result_type             item;
      n = active_count(node_limit);
      for (i = 0; i < n; i++) begin
         reach[i]   = arc_cost[src][i];
         via[i]     = src;
         settled[i] = 1'b0;
      end
      reach[src]   = '0;
      settled[src] = 1'b1;
      // at most n-2 nodes get settled; stop early once nothing reachable is left
      for (round = 1; round + 1 < n; round++) begin
         nearest = 32'(dgsp_pkg::NO_EDGE);
         pick    = 0;
         found   = 1'b0;
         for (i = 0; i < n; i++) begin
            if (!settled[i] && reach[i] < nearest) begin
               nearest = 32'(reach[i]);
               pick    = i;
               found   = 1'b1;
            end
         end
         if (!found) break;
         settled[pick] = 1'b1;
         for (i = 0; i < n; i++) begin
            cand = nearest + 32'(arc_cost[pick][i]);
            if (!settled[i] && cand < reach[i]) begin
               reach[i] = dgsp_pkg::DIST_W'(cand);
               via[i]   = dgsp_pkg::NODE_W'(pick);
            end
         end
      end
      final_node = (src == n - 1) ? n - 2 : n - 1;
      for (i = 0; i < n; i++) begin
         if (i != src) begin
            item.node        = dgsp_pkg::NODE_W'(i);
            item.distance    = reach[i];
            item.predecessor = via[i];
            item.last        = (i == final_node);
            expected_paths.push_back(item);
         end
      end
   endtask

   // results are checked before new items are predicted on the same edge
   always @(posedge clock) begin
      path_result_type             want;
      logic [dgsp_pkg::NODE_W-1:0] got_node, got_pred, src;
      logic [dgsp_pkg::DIST_W-1:0] got_dist, weight;
      if (reset) begin
         expected_paths.delete();
         node_limit = dgsp_pkg::NODE_COUNT_RST;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_node = rsp_tdata[0 +: dgsp_pkg::NODE_W];
            got_dist = rsp_tdata[dgsp_pkg::NODE_W +: dgsp_pkg::DIST_W];
            got_pred = rsp_tdata[dgsp_pkg::NODE_W + dgsp_pkg::DIST_W +: dgsp_pkg::NODE_W];
            if (expected_paths.size() == 0) begin
               $error("unexpected result item: node %0d distance %0d predecessor %0d",
                      got_node, got_dist, got_pred);
               fail_count++;
            end else begin
               want = expected_paths.pop_front();
               if (got_node !== want.node) begin
                  $error("node: expected %0d, got %0d", want.node, got_node);
                  fail_count++;
               end
               if (got_dist !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, got_dist);
                  fail_count++;
               end
               if (got_pred !== want.predecessor) begin
                  $error("predecessor: expected %0d, got %0d", want.predecessor, got_pred);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            src = req_tdata[dgsp_pkg::SOURCE_LSB +: dgsp_pkg::NODE_W];
            if (req_tuser == dgsp_pkg::REQ_LOAD) begin
               // weights above the no-edge code saturate to it
               weight = req_tdata[dgsp_pkg::WEIGHT_LSB +: dgsp_pkg::DIST_W];
               if (weight > dgsp_pkg::NO_EDGE) weight = dgsp_pkg::NO_EDGE;
               arc_cost[req_tdata[dgsp_pkg::ROW_LSB +: dgsp_pkg::NODE_W]]
                       [req_tdata[dgsp_pkg::COL_LSB +: dgsp_pkg::NODE_W]] = weight;
            end else if (src < active_count(node_limit)) begin
               solve_from(src);
            end
         end
         if (csr_we) node_limit = csr_wdata;
      end
      pending = expected_paths.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int MAX_NODES     = 32;
   localparam int SETTLE_CYCLES = 2 * (MAX_NODES + 1) * (MAX_NODES + 1);
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASES        = 4;
   localparam int MIXED_ITEMS   = 5;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dgsp_pkg::REQ_DATA_W-1:0] req_tdata;    // row, col, weight, source
   logic                            req_tuser;    // req_type
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dgsp_pkg::RSP_DATA_W-1:0] rsp_tdata;    // node, distance, predecessor
   logic                            rsp_tlast;
   logic                            csr_we;
   logic [dgsp_pkg::CNT_REG_W-1:0]  csr_wdata;    // node_count

   int                    pending;
   int                    fail_count;
   int                    cycles_run = 0;
   int unsigned           rsp_pause = 0;
   int unsigned           rsp_draw;
   logic                  send_eager = 1'b0;
   logic                  recv_eager = 1'b0;
   bit                    written [32][32];
   int                    span;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dense_graph_shortest_paths #(.MAX_NODES(MAX_NODES)) dut (.*);

   dgsp_path_checker #(.MAX_NODES(MAX_NODES)) path_check (.*);

   // run guard
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("dense_graph_shortest_paths: mismatch");
         $finish;
      end
   end

   // result side: after each item hold tready low for a randomly drawn pause
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_pause  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_draw = recv_eager ? 0 : $urandom_range(0, 3);
         rsp_pause  <= rsp_draw;
         rsp_tready <= (rsp_draw == 0);
      end else if (rsp_pause > 1) begin
         rsp_pause <= rsp_pause - 1;
      end else begin
         rsp_pause  <= 0;
         rsp_tready <= 1'b1;
      end
   end

   function automatic int clamp_nodes(input logic [dgsp_pkg::CNT_REG_W-1:0] value);
      int n;
      n = int'(value);
      if (n < 2) n = 2;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
   endfunction

   // mix of no-edge, saturating, zero, heavy and light weights
   function automatic logic [dgsp_pkg::DIST_W-1:0] draw_weight();
      case ($urandom_range(0, 9))
         0, 1, 2: return dgsp_pkg::NO_EDGE;
         3:       return dgsp_pkg::DIST_W'($urandom_range(1000, 1023));
         4:       return '0;
         5:       return dgsp_pkg::DIST_W'($urandom_range(500, 998));
         default: return dgsp_pkg::DIST_W'($urandom_range(1, 40));
      endcase
   endfunction

   // present one item after a random gap and wait for its handshake
   task automatic push_item(input logic kind, input logic [dgsp_pkg::NODE_W-1:0] row,
                            input logic [dgsp_pkg::NODE_W-1:0] col,
                            input logic [dgsp_pkg::DIST_W-1:0] weight,
                            input logic [dgsp_pkg::NODE_W-1:0] src);
      int                              gap;
      logic [dgsp_pkg::REQ_DATA_W-1:0] word;
      gap = send_eager ? 0 : $urandom_range(0, 3);
      word = '0;
      word[dgsp_pkg::ROW_LSB +: dgsp_pkg::NODE_W]    = row;
      word[dgsp_pkg::COL_LSB +: dgsp_pkg::NODE_W]    = col;
      word[dgsp_pkg::WEIGHT_LSB +: dgsp_pkg::DIST_W] = weight;
      word[dgsp_pkg::SOURCE_LSB +: dgsp_pkg::NODE_W] = src;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // unused fields carry random bits
   task automatic load_cost(input int row, input int col,
                            input logic [dgsp_pkg::DIST_W-1:0] weight);
      push_item(dgsp_pkg::REQ_LOAD, dgsp_pkg::NODE_W'(row), dgsp_pkg::NODE_W'(col), weight,
                dgsp_pkg::NODE_W'($urandom));
      written[row][col] = 1'b1;
   endtask

   task automatic run_from(input int src);
      push_item(dgsp_pkg::REQ_RUN, dgsp_pkg::NODE_W'($urandom), dgsp_pkg::NODE_W'($urandom),
                dgsp_pkg::DIST_W'($urandom), dgsp_pkg::NODE_W'(src));
   endtask

   // hold off until every result is in, then let a silent run finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_node_count(input logic [dgsp_pkg::CNT_REG_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      span = clamp_nodes(value);
   endtask

   initial begin
      int phase, k, r, c;
      logic [dgsp_pkg::CNT_REG_W-1:0] count_value;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= dgsp_pkg::REQ_LOAD;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // two nodes via a register value below range
      write_node_count('0);
      load_cost(0, 0, 0);
      load_cost(0, 1, 10'd1023);    // saturates to no edge
      load_cost(1, 0, 0);
      load_cost(1, 1, dgsp_pkg::NO_EDGE);
      run_from(0);
      run_from(1);
      run_from(2);                  // source beyond active nodes: ignored
      run_from(31);
      load_cost(0, 1, 10'd998);
      run_from(0);
      write_node_count(6'd1);
      run_from(1);

      // three nodes: relaxing through node 1, and a source with nothing reachable
      write_node_count(6'd3);
      load_cost(0, 1, 4);
      load_cost(0, 2, 10);
      load_cost(1, 2, 3);
      load_cost(2, 0, dgsp_pkg::NO_EDGE);
      load_cost(2, 1, dgsp_pkg::NO_EDGE);
      load_cost(2, 2, 0);
      run_from(0);
      run_from(2);

      // full size via a register value above range; nothing reachable from the
      // last node, so only its row is read
      write_node_count('1);
      for (c = 0; c < MAX_NODES; c++) begin
         if ($urandom_range(0, 1) == 1)
            load_cost(MAX_NODES - 1, c, dgsp_pkg::NO_EDGE);
         else
            load_cost(MAX_NODES - 1, c, dgsp_pkg::DIST_W'($urandom_range(1000, 1023)));
      end
      run_from(MAX_NODES - 1);

      // random phases: new node count, fresh matrix, then runs mixed with loads
      for (phase = 0; phase < PHASES; phase++) begin
         if ($urandom_range(0, 9) < 8)
            count_value = dgsp_pkg::CNT_REG_W'($urandom_range(2, 5));
         else
            count_value = dgsp_pkg::CNT_REG_W'($urandom_range(0, 1));
         write_node_count(count_value);
         send_eager = ($urandom_range(0, 3) == 0);
         recv_eager = ($urandom_range(0, 3) == 0);
         for (r = 0; r < span; r++) begin
            for (c = 0; c < span; c++) begin
               if (!written[r][c] || $urandom_range(0, 3) == 0)
                  load_cost(r, c, draw_weight());
            end
         end
         for (k = 0; k < MIXED_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 65) begin
               if ($urandom_range(0, 9) == 0)
                  run_from($urandom_range(0, 31));
               else
                  run_from($urandom_range(0, span - 1));
            end else begin
               load_cost($urandom_range(0, 31), $urandom_range(0, 31), draw_weight());
            end
         end
      end

      wait_idle();
      if (fail_count == 0 && pending == 0)
         $display("dense_graph_shortest_paths: match");
      else
         $display("dense_graph_shortest_paths: mismatch");
      $finish;
   end

endmodule

[sim.f]
rtl/dgsp_pkg.sv
rtl/dense_graph_shortest_paths.sv
test/dgsp_path_checker.sv
test/tb_top.sv
